/* rtl/ofu_pkg.sv */
package ofu_pkg;

  localparam int FRAC_BITS    = 30;
  localparam int CORDIC_STEPS = 32;

  // working width of vector components and multiplier operands
  localparam int VW  = 34;
  localparam int PW  = 2 * VW;
  localparam int ZW  = 36;
  localparam int CNT_W = 6;
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  localparam int DSH = 60 - 2 * FRAC_BITS;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic signed [VW-1:0] ONE_FX  = VW'(64'd1 << FRAC_BITS);
  localparam logic signed [VW-1:0] HALF_FX = VW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [VW-1:0] ONE_Q30 = VW'(64'd1 << 30);
  localparam logic signed [31:0]   ONE32   = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [PW-1:0] RND_F   = PW'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [PW-1:0] RND_30  = PW'(64'd1 << 29);
  localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [VW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic [30:0] TOL_RESET = 31'd10737;

  typedef enum logic [1:0] {
    K_ROTATE    = 2'd0,
    K_SET_UP    = 2'd1,
    K_SET_FRONT = 2'd2,
    K_NONE      = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic               nop;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] angle;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_UABS, S_UNRM, S_USQ, S_USQRT, S_UDLD, S_UDIV, S_UWR,
    S_CINIT, S_CORD, S_CFIN, S_RKV, S_RCR, S_RKK, S_RACC,
    S_PTOL, S_PDM, S_PDP, S_ODOT, S_ORES, S_FALLBK, S_OUT
  } back_state_e;

  function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] i);
    case (i)
      6'd0:  return 30'd843314856;
      6'd1:  return 30'd497837829;
      6'd2:  return 30'd263043836;
      6'd3:  return 30'd133525158;
      6'd4:  return 30'd67021686;
      6'd5:  return 30'd33543515;
      6'd6:  return 30'd16775850;
      6'd7:  return 30'd8388437;
      6'd8:  return 30'd4194282;
      6'd9:  return 30'd2097149;
      6'd10: return 30'd1048575;
      6'd11: return 30'd524287;
      6'd12: return 30'd262143;
      6'd13: return 30'd131071;
      6'd14: return 30'd65535;
      6'd15: return 30'd32767;
      6'd16: return 30'd16383;
      6'd17: return 30'd8191;
      6'd18: return 30'd4095;
      6'd19: return 30'd2047;
      6'd20: return 30'd1023;
      6'd21: return 30'd511;
      6'd22: return 30'd255;
      6'd23: return 30'd127;
      6'd24: return 30'd63;
      6'd25: return 30'd31;
      6'd26: return 30'd15;
      6'd27: return 30'd8;
      6'd28: return 30'd4;
      6'd29: return 30'd2;
      6'd30: return 30'd1;
      default: return 30'd0;
    endcase
  endfunction

endpackage

/* rtl/ofu_front.sv */
module ofu_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] angle_i,
  input  ofu_pkg::q_stat_t   q_stat_i,
  output logic               q_push_o,
  output ofu_pkg::cmd_t      q_cmd_o
);
  import ofu_pkg::*;

  kind_e kind;

  assign kind       = kind_e'(kind_i);
  assign in_stall_o = q_stat_i.full;
  assign q_push_o   = in_valid_i && !q_stat_i.full;

  // kind 3 and zero-angle rotations leave the frame as it is and skip the arithmetic
  always_comb begin
    q_cmd_o.kind  = kind;
    q_cmd_o.nop   = (kind == K_NONE) || ((kind == K_ROTATE) && (angle_i == 32'sd0));
    q_cmd_o.vx    = vec_x_i;
    q_cmd_o.vy    = vec_y_i;
    q_cmd_o.vz    = vec_z_i;
    q_cmd_o.angle = angle_i;
  end

endmodule

/* rtl/ofu_queue.sv */
module ofu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ofu_pkg::cmd_t    cmd_i,
  output ofu_pkg::q_stat_t stat_o,
  input  logic             pop_i,
  output logic             valid_o,
  output ofu_pkg::cmd_t    cmd_o
);
  import ofu_pkg::*;

  cmd_t             mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     cnt_q;

  assign stat_o.full  = (cnt_q == (QAW+1)'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign valid_o      = !stat_o.empty;
  assign cmd_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/ofu_back.sv */
module ofu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  ofu_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  logic [30:0]        tol_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic signed [31:0] up_x_o,
  output logic signed [31:0] up_y_o,
  output logic signed [31:0] up_z_o,
  output logic signed [31:0] front_x_o,
  output logic signed [31:0] front_y_o,
  output logic signed [31:0] front_z_o,
  output logic               bad_input_o
);
  import ofu_pkg::*;

  back_state_e state_q, state_d;

  logic signed [VW-1:0] up_q [3];
  logic signed [VW-1:0] fr_q [3];
  logic signed [VW-1:0] kn_q [3];
  logic signed [VW-1:0] us_q [3];
  logic signed [VW-1:0] cr_q [3];
  logic signed [VW-1:0] kk_q [3];
  logic signed [VW-1:0] ov [3];
  logic signed [VW-1:0] tv [3];
  logic [VW:0]          m_q [3];
  logic [VW:0]          mx;

  kind_e              kind_q;
  logic signed [31:0] angle_q;
  logic               bad_q, ucall_q, tsel_q, par_q, flip_q;

  logic [63:0] sq_n_q, sq_r_q, sq_b_q;
  logic [64:0] sq_rb;
  logic [31:0] root;
  logic [63:0] dvd_full;
  logic [31:0] dvd_q, rem_q, quo_q;
  logic [32:0] dv_t;
  logic        dv_ge;
  logic signed [VW-1:0] quo_s;

  logic signed [VW-1:0] cx_q, cy_q, c_q, s_q, kv_q, omc;
  logic signed [ZW-1:0] cz_q, z0, atan_v;

  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       comp_q, term_q, ucomp_q;
  logic             ph_q;

  logic signed [VW-1:0] mul_a, mul_b, mul_ae;
  logic                 mul_neg;
  logic signed [PW-1:0] prod_q, acc_q, sum, rnd_f, rnd_30;
  logic [63:0]          t2_q, dsq;
  logic                 mac_st, last_t, last_c, mac_end, par_now;
  logic signed [VW-1:0] rot_o;

  logic                 out_vld_q, out_load;
  logic signed [31:0]   o_up_q [3];
  logic signed [31:0]   o_fr_q [3];
  logic                 o_bad_q;

  function automatic logic [1:0] idx3(input logic [2:0] v);
    case (v)
      3'd0, 3'd3: return 2'd0;
      3'd1, 3'd4: return 2'd1;
      3'd2:       return 2'd2;
      default:    return 2'd0;
    endcase
  endfunction

  // old vector of the frame for set commands, rotated vector for rotate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ov[i] = (kind_q == K_SET_UP) ? fr_q[i] : up_q[i];
      tv[i] = tsel_q ? fr_q[i] : up_q[i];
    end
  end

  // ---------------- shared multiply-accumulate ----------------
  assign omc = ONE_Q30 - c_q;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mac_st  = 1'b1;
    last_t  = 1'b1;
    last_c  = 1'b1;
    case (state_q)
      S_USQ: begin
        mul_a  = $signed({2'b00, m_q[term_q][31:0]});
        mul_b  = mul_a;
        last_t = (term_q == 2'd2);
      end
      S_PTOL: begin
        mul_a = $signed({3'b000, tol_i});
        mul_b = mul_a;
      end
      S_PDM: begin
        mul_a  = ov[term_q] - kn_q[term_q];
        mul_b  = mul_a;
        last_t = (term_q == 2'd2);
      end
      S_PDP: begin
        mul_a  = ov[term_q] + kn_q[term_q];
        mul_b  = mul_a;
        last_t = (term_q == 2'd2);
      end
      S_ODOT: begin
        mul_a  = ov[term_q];
        mul_b  = kn_q[term_q];
        last_t = (term_q == 2'd2);
      end
      S_ORES: begin
        mul_a  = kv_q;
        mul_b  = kn_q[comp_q];
        last_c = (comp_q == 2'd2);
      end
      S_RKV: begin
        mul_a  = kn_q[term_q];
        mul_b  = tv[term_q];
        last_t = (term_q == 2'd2);
      end
      S_RCR: begin
        // cross product: k[i+1]*v[i+2] - k[i+2]*v[i+1]
        mul_a   = kn_q[idx3(3'(comp_q) + 3'd1 + 3'(term_q))];
        mul_b   = tv[idx3(3'(comp_q) + 3'd2 - 3'(term_q))];
        mul_neg = term_q[0];
        last_t  = (term_q == 2'd1);
        last_c  = (comp_q == 2'd2);
      end
      S_RKK: begin
        mul_a  = kn_q[comp_q];
        mul_b  = kv_q;
        last_c = (comp_q == 2'd2);
      end
      S_RACC: begin
        case (term_q)
          2'd0: begin
            mul_a = tv[comp_q];
            mul_b = c_q;
          end
          2'd1: begin
            mul_a = cr_q[comp_q];
            mul_b = s_q;
          end
          default: begin
            mul_a = kk_q[comp_q];
            mul_b = omc;
          end
        endcase
        last_t = (term_q == 2'd2);
        last_c = (comp_q == 2'd2);
      end
      default: mac_st = 1'b0;
    endcase
  end

  assign mul_ae  = mul_neg ? -mul_a : mul_a;
  assign sum     = acc_q + prod_q;
  assign rnd_f   = (sum + RND_F) >>> FRAC_BITS;
  assign rnd_30  = (sum + RND_30) >>> 30;
  assign dsq     = sum[63:0] << DSH;
  assign par_now = (dsq < t2_q);
  assign mac_end = mac_st && ph_q && last_t && last_c;

  always_comb begin
    if (rnd_30 > PW'(ONE_FX)) begin
      rot_o = ONE_FX;
    end else if (rnd_30 < -PW'(ONE_FX)) begin
      rot_o = -ONE_FX;
    end else begin
      rot_o = rnd_30[VW-1:0];
    end
  end

  // ---------------- normalisation helpers ----------------
  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) begin
      mx = m_q[1];
    end
    if (m_q[2] > mx) begin
      mx = m_q[2];
    end
  end

  assign sq_rb    = {1'b0, sq_r_q} + {1'b0, sq_b_q};
  assign root     = sq_r_q[31:0];
  assign dvd_full = ({32'd0, m_q[ucomp_q][31:0]} << FRAC_BITS) + {33'd0, root[31:1]};
  assign dv_t     = {rem_q, dvd_q[31]};
  assign dv_ge    = (dv_t >= {1'b0, root});
  assign quo_s    = us_q[ucomp_q][VW-1] ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});

  assign z0     = $signed({{3{angle_q[31]}}, angle_q, 1'b0});
  assign atan_v = $signed({6'd0, atan_q30(cnt_q)});

  // ---------------- sequencer ----------------
  assign out_load  = (state_q == S_OUT) && (!out_vld_q || !res_stall_i);
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          state_d = cmd_i.nop ? S_OUT : S_UABS;
        end
      end
      S_UABS: state_d = S_UNRM;
      S_UNRM: begin
        if (mx == '0) begin
          state_d = ucall_q ? S_FALLBK : S_OUT;
        end else if (mx <= (VW+1)'(64'd1 << 31) && mx >= (VW+1)'(64'd1 << 30)) begin
          state_d = S_USQ;
        end
      end
      S_USQ:   if (mac_end) state_d = S_USQRT;
      S_USQRT: if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = S_UDLD;
      S_UDLD:  state_d = S_UDIV;
      S_UDIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = S_UWR;
      S_UWR: begin
        if (ucomp_q != 2'd2) begin
          state_d = S_UDLD;
        end else if (ucall_q) begin
          state_d = S_OUT;
        end else if (kind_q == K_ROTATE) begin
          state_d = S_CINIT;
        end else begin
          state_d = S_PTOL;
        end
      end
      S_CINIT: state_d = S_CORD;
      S_CORD:  if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = S_CFIN;
      S_CFIN:  state_d = S_RKV;
      S_RKV:   if (mac_end) state_d = S_RCR;
      S_RCR:   if (mac_end) state_d = S_RKK;
      S_RKK:   if (mac_end) state_d = S_RACC;
      S_RACC:  if (mac_end) state_d = tsel_q ? S_OUT : S_RKV;
      S_PTOL:  if (mac_end) state_d = S_PDM;
      S_PDM:   if (mac_end) state_d = S_PDP;
      S_PDP:   if (mac_end) state_d = (par_q || par_now) ? S_FALLBK : S_ODOT;
      S_ODOT:  if (mac_end) state_d = S_ORES;
      S_ORES:  if (mac_end) state_d = S_UABS;
      S_FALLBK: state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // frame state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0]   <= '0;
      up_q[1]   <= '0;
      up_q[2]   <= ONE_FX;
      fr_q[0]   <= '0;
      fr_q[1]   <= ONE_FX;
      fr_q[2]   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!res_stall_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_UWR: begin
          if (ucall_q) begin
            if (kind_q == K_SET_UP) begin
              fr_q[ucomp_q] <= quo_s;
              if (ucomp_q == 2'd2) begin
                up_q <= kn_q;
              end
            end else begin
              up_q[ucomp_q] <= quo_s;
              if (ucomp_q == 2'd2) begin
                fr_q <= kn_q;
              end
            end
          end
        end
        S_RACC: begin
          if (ph_q && last_t) begin
            if (tsel_q) begin
              fr_q[comp_q] <= rot_o;
            end else begin
              up_q[comp_q] <= rot_o;
            end
          end
        end
        S_FALLBK: begin
          if (kind_q == K_SET_UP) begin
            up_q     <= kn_q;
            fr_q[0]  <= '0;
            if (kn_q[2] < HALF_FX && kn_q[2] > -HALF_FX) begin
              fr_q[1] <= -ONE_FX;
              fr_q[2] <= '0;
            end else begin
              fr_q[1] <= '0;
              fr_q[2] <= ONE_FX;
            end
          end else begin
            fr_q    <= kn_q;
            up_q[2] <= '0;
            if (kn_q[1] < HALF_FX && kn_q[1] > -HALF_FX) begin
              up_q[0] <= ONE_FX;
              up_q[1] <= '0;
            end else begin
              up_q[0] <= '0;
              up_q[1] <= ONE_FX;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        o_up_q[i] <= up_q[i][31:0];
        o_fr_q[i] <= fr_q[i][31:0];
      end
      o_bad_q <= bad_q;
    end

    if (mac_st) begin
      if (!ph_q) begin
        prod_q <= mul_ae * mul_b;
        ph_q   <= 1'b1;
      end else begin
        ph_q <= 1'b0;
        if (last_t) begin
          acc_q  <= '0;
          term_q <= '0;
          comp_q <= last_c ? 2'd0 : comp_q + 2'd1;
        end else begin
          acc_q  <= sum;
          term_q <= term_q + 2'd1;
        end
      end
    end else begin
      acc_q  <= '0;
      term_q <= '0;
      comp_q <= '0;
      ph_q   <= 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        kind_q  <= cmd_i.kind;
        angle_q <= cmd_i.angle;
        us_q[0] <= VW'(cmd_i.vx);
        us_q[1] <= VW'(cmd_i.vy);
        us_q[2] <= VW'(cmd_i.vz);
        bad_q   <= 1'b0;
        ucall_q <= 1'b0;
        tsel_q  <= 1'b0;
        par_q   <= 1'b0;
      end
      S_UABS: begin
        for (int i = 0; i < 3; i++) begin
          m_q[i] <= us_q[i][VW-1] ? (VW+1)'(0) - {us_q[i][VW-1], us_q[i]}
                                  : {us_q[i][VW-1], us_q[i]};
        end
        ucomp_q <= '0;
      end
      S_UNRM: begin
        if (mx == '0) begin
          bad_q <= !ucall_q;
        end else if (mx > (VW+1)'(64'd1 << 31)) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        end else if (mx < (VW+1)'(64'd1 << 30)) begin
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end
      end
      S_USQ: begin
        if (ph_q && last_t) begin
          sq_n_q <= sum[63:0];
          sq_r_q <= '0;
          sq_b_q <= 64'd1 << 62;
          cnt_q  <= '0;
        end
      end
      S_USQRT: begin
        if ({1'b0, sq_n_q} >= sq_rb) begin
          sq_n_q <= sq_n_q - sq_rb[63:0];
          sq_r_q <= (sq_r_q >> 1) + sq_b_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_b_q <= sq_b_q >> 2;
        cnt_q  <= cnt_q + 1'b1;
      end
      S_UDLD: begin
        rem_q <= dvd_full[63:32];
        dvd_q <= dvd_full[31:0];
        quo_q <= '0;
        cnt_q <= '0;
      end
      S_UDIV: begin
        rem_q <= dv_ge ? 32'(dv_t - {1'b0, root}) : dv_t[31:0];
        quo_q <= {quo_q[30:0], dv_ge};
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q + 1'b1;
      end
      S_UWR: begin
        if (!ucall_q) begin
          kn_q[ucomp_q] <= quo_s;
        end
        ucomp_q <= ucomp_q + 2'd1;
      end
      S_CINIT: begin
        // fold the angle into the CORDIC range, negating the result
        if (z0 > HALF_PI_Q30) begin
          cz_q   <= z0 - PI_Q30;
          flip_q <= 1'b1;
        end else if (z0 < -HALF_PI_Q30) begin
          cz_q   <= z0 + PI_Q30;
          flip_q <= 1'b1;
        end else begin
          cz_q   <= z0;
          flip_q <= 1'b0;
        end
        cx_q  <= GAIN_Q30;
        cy_q  <= '0;
        cnt_q <= '0;
      end
      S_CORD: begin
        if (!cz_q[ZW-1]) begin
          cx_q <= cx_q - (cy_q >>> cnt_q);
          cy_q <= cy_q + (cx_q >>> cnt_q);
          cz_q <= cz_q - atan_v;
        end else begin
          cx_q <= cx_q + (cy_q >>> cnt_q);
          cy_q <= cy_q - (cx_q >>> cnt_q);
          cz_q <= cz_q + atan_v;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      S_CFIN: begin
        c_q <= flip_q ? -cx_q : cx_q;
        s_q <= flip_q ? -cy_q : cy_q;
      end
      S_RKV, S_ODOT: begin
        if (ph_q && last_t) kv_q <= rnd_f[VW-1:0];
      end
      S_RCR: begin
        if (ph_q && last_t) cr_q[comp_q] <= rnd_f[VW-1:0];
      end
      S_RKK: begin
        if (ph_q && last_t) kk_q[comp_q] <= rnd_f[VW-1:0];
      end
      S_RACC: begin
        if (mac_end) tsel_q <= 1'b1;
      end
      S_PTOL: begin
        if (ph_q && last_t) t2_q <= sum[63:0];
      end
      S_PDM: begin
        if (ph_q && last_t) par_q <= par_now;
      end
      S_ORES: begin
        if (ph_q && last_t) begin
          us_q[comp_q] <= ov[comp_q] - rnd_f[VW-1:0];
        end
        if (mac_end) ucall_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign res_valid_o = out_vld_q;
  assign up_x_o      = o_up_q[0];
  assign up_y_o      = o_up_q[1];
  assign up_z_o      = o_up_q[2];
  assign front_x_o   = o_fr_q[0];
  assign front_y_o   = o_fr_q[1];
  assign front_z_o   = o_fr_q[2];
  assign bad_input_o = o_bad_q;

endmodule

/* rtl/orientation_frame_update.sv */
// Orientation frame update: keeps an orthonormal up/front frame (Q2.30).
//
// Input channel (in_valid_i / in_stall_o): one command per transaction,
// kind 0 rotates the frame about vec_* by angle_i, kind 1 sets the up
// vector, kind 2 sets the front vector, kind 3 does nothing.
// Output channel (out_valid_o / out_stall_i): one transaction per command
// carrying the frame after it, with bad_input_o set for a zero vector.
// Config channel (cfg_valid_i / cfg_ready_o): writes parallel_tolerance;
// always ready, write only while no command is in flight.
// Commands pass through a two-entry queue into a sequencer built around one
// shared 34x34 multiplier, a one-bit-per-cycle square root and divider and a
// CORDIC. A no-op command (kind 3, or a zero angle) goes straight to the
// output; a vector normalisation takes 32 root steps, 3 x 32 divide steps
// and up to 30 alignment shifts; a rotation adds 32 CORDIC steps and 42
// multiplies, a set command adds a parallel test and a Gram-Schmidt step plus
// a second normalisation. One command is processed at a time.
// Reset gives up = (0,0,1), front = (0,1,0), tolerance 10737, empty queue.
// While out_stall_i is high the result is held and the queue keeps accepting
// until it is full, then in_stall_o rises.
module orientation_frame_update (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] up_x_o,
  output logic signed [31:0] up_y_o,
  output logic signed [31:0] up_z_o,
  output logic signed [31:0] front_x_o,
  output logic signed [31:0] front_y_o,
  output logic signed [31:0] front_z_o,
  output logic               bad_input_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_data_i
);
  import ofu_pkg::*;

  q_stat_t     q_stat;
  logic        q_push, q_valid, q_pop;
  cmd_t        q_in, q_out;
  logic [30:0] tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  ofu_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .vec_x_i    (vec_x_i),
    .vec_y_i    (vec_y_i),
    .vec_z_i    (vec_z_i),
    .angle_i    (angle_i),
    .q_stat_i   (q_stat),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in)
  );

  ofu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .stat_o  (q_stat),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_out)
  );

  ofu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_out),
    .cmd_pop_o   (q_pop),
    .tol_i       (tol_q),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .up_x_o      (up_x_o),
    .up_y_o      (up_y_o),
    .up_z_o      (up_z_o),
    .front_x_o   (front_x_o),
    .front_y_o   (front_y_o),
    .front_z_o   (front_z_o),
    .bad_input_o (bad_input_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("command queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("command queue read while empty");

  a_up_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (up_x_o <= ONE32 && up_x_o >= -ONE32 &&
                     up_y_o <= ONE32 && up_y_o >= -ONE32 &&
                     up_z_o <= ONE32 && up_z_o >= -ONE32))
    else $error("up vector component beyond unit range");

  a_front_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (front_x_o <= ONE32 && front_x_o >= -ONE32 &&
                     front_y_o <= ONE32 && front_y_o >= -ONE32 &&
                     front_z_o <= ONE32 && front_z_o >= -ONE32))
    else $error("front vector component beyond unit range");

endmodule

/* tb/orientation_frame_update_tb.sv */
`timescale 1ns / 1ps

module orientation_frame_update_tb;
  import ofu_pkg::*;

  localparam logic [31:0] P1 = 32'sh4000_0000;
  localparam logic [31:0] M1 = 32'shC000_0000;
  localparam longint MAX_ANG = 1686629713;
  localparam longint PI_FX = 64'd3373259426;
  localparam longint GAIN_FX = 64'd652032874;
  localparam longint ATAN_TAB [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2, 1, 0};

  typedef struct packed {
    logic [31:0] ux, uy, uz, fx, fy, fz;
    logic        bad;
  } frame_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] x, y, z, a;
    logic        typed;
    frame_t      ex;
  } cmd_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  kind_e kind = K_NONE;
  logic signed [31:0] vx = '0, vy = '0, vz = '0, ang = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  logic signed [31:0] up_x_o, up_y_o, up_z_o, front_x_o, front_y_o, front_z_o;
  logic bad_input_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [30:0] cfg_data = '0;

  frame_t frame_q[$];
  longint up_v[3], front_v[3];
  longint tol;
  int send_idle = 8, recv_idle = 53;
  bit failed = 0;
  cmd_row_t dir_rows[19];

  orientation_frame_update i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall_o), .kind_i(kind),
    .vec_x_i(vx), .vec_y_i(vy), .vec_z_i(vz), .angle_i(ang),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall),
    .up_x_o(up_x_o), .up_y_o(up_y_o), .up_z_o(up_z_o),
    .front_x_o(front_x_o), .front_y_o(front_y_o), .front_z_o(front_z_o),
    .bad_input_o(bad_input_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("orientation_frame_update_tb: FAIL");
    $finish;
  end

  // ---------------- frame predictor ----------------
  function automatic longint rnd(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit normalise(input longint v[3], output longint r[3]);
    longint unsigned m[3], mx, n2, n, q;
    mx = 0;
    n2 = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? longint'(-v[i]) : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 0;
    while (mx > (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) n2 += m[i] * m[i];
    n = isqrt(n2);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS) + n / 2) / n;
      r[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic longint unsigned gap2(input longint a[3], input longint b[3],
                                           input longint sgn);
    longint unsigned s, m;
    longint d;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      d = a[i] - sgn * b[i];
      m = d < 0 ? longint'(-d) : d;
      s += m * m;
    end
    return s << DSH;
  endfunction

  function automatic bit is_parallel(input longint a[3], input longint b[3]);
    longint unsigned t2;
    t2 = longint'(tol) * tol;
    return gap2(a, b, 1) < t2 || gap2(a, b, -1) < t2;
  endfunction

  function automatic bit gram_schmidt(input longint old[3], input longint nv[3],
                                      output longint r[3]);
    longint d, res[3];
    d = rnd(old[0] * nv[0] + old[1] * nv[1] + old[2] * nv[2], FRAC_BITS);
    for (int i = 0; i < 3; i++) res[i] = old[i] - rnd(d * nv[i], FRAC_BITS);
    return normalise(res, r);
  endfunction

  task automatic cordic_sin_cos(input longint a29, output longint c, output longint s);
    longint z, x, y, xs, ys;
    bit flip;
    z = a29 * 2;
    x = GAIN_FX;
    y = 0;
    flip = 0;
    if (z > MAX_ANG) begin
      z -= PI_FX;
      flip = 1;
    end else if (z < -MAX_ANG) begin
      z += PI_FX;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= (i < 32 ? ATAN_TAB[i] : 0);
      end else begin
        x += ys; y -= xs; z += (i < 32 ? ATAN_TAB[i] : 0);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic void rodrigues(input longint k[3], input longint v[3],
                                    input longint c, input longint s, output longint r[3]);
    longint kv, cr[3], acc, o;
    kv = rnd(k[0] * v[0] + k[1] * v[1] + k[2] * v[2], FRAC_BITS);
    cr[0] = rnd(k[1] * v[2] - k[2] * v[1], FRAC_BITS);
    cr[1] = rnd(k[2] * v[0] - k[0] * v[2], FRAC_BITS);
    cr[2] = rnd(k[0] * v[1] - k[1] * v[0], FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      acc = v[i] * c + cr[i] * s + rnd(k[i] * kv, FRAC_BITS) * ((longint'(1) << 30) - c);
      o = rnd(acc, 30);
      if (o > (longint'(1) << FRAC_BITS)) o = longint'(1) << FRAC_BITS;
      if (o < -(longint'(1) << FRAC_BITS)) o = -(longint'(1) << FRAC_BITS);
      r[i] = o;
    end
  endfunction

  task automatic apply_cmd(input kind_e k, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] z,
                           input logic signed [31:0] a, output frame_t f);
    longint v[3], nu[3], nf[3], c, s, mag;
    longint one_fx, half_fx;
    bit bad;
    one_fx = longint'(1) << FRAC_BITS;
    half_fx = longint'(1) << (FRAC_BITS - 1);
    bad = 0;
    v[0] = longint'(x); v[1] = longint'(y); v[2] = longint'(z);
    case (k)
      K_ROTATE: begin
        if (a != 0) begin
          if (!normalise(v, nu)) begin
            bad = 1;
          end else begin
            cordic_sin_cos(longint'(a), c, s);
            rodrigues(nu, up_v, c, s, nf);
            rodrigues(nu, front_v, c, s, v);
            up_v = nf;
            front_v = v;
          end
        end
      end
      K_SET_UP: begin
        if (!normalise(v, nu)) begin
          bad = 1;
        end else begin
          if (is_parallel(front_v, nu) || !gram_schmidt(front_v, nu, nf)) begin
            mag = nu[2] < 0 ? -nu[2] : nu[2];
            nf[0] = 0;
            nf[1] = mag < half_fx ? -one_fx : 0;
            nf[2] = mag < half_fx ? 0 : one_fx;
          end
          up_v = nu;
          front_v = nf;
        end
      end
      K_SET_FRONT: begin
        if (!normalise(v, nf)) begin
          bad = 1;
        end else begin
          if (is_parallel(nf, up_v) || !gram_schmidt(up_v, nf, nu)) begin
            mag = nf[1] < 0 ? -nf[1] : nf[1];
            nu[0] = mag < half_fx ? one_fx : 0;
            nu[1] = mag < half_fx ? 0 : one_fx;
            nu[2] = 0;
          end
          up_v = nu;
          front_v = nf;
        end
      end
      default: ;
    endcase
    f.ux = 32'(up_v[0]); f.uy = 32'(up_v[1]); f.uz = 32'(up_v[2]);
    f.fx = 32'(front_v[0]); f.fy = 32'(front_v[1]); f.fz = 32'(front_v[2]);
    f.bad = bad;
  endtask

  // ---------------- result checker ----------------
  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
               $signed(e), $signed(a));
      failed = 1;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_t e;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (frame_q.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $time);
        failed = 1;
      end else begin
        e = frame_q.pop_front();
        check_field("up_x", e.ux, up_x_o);
        check_field("up_y", e.uy, up_y_o);
        check_field("up_z", e.uz, up_z_o);
        check_field("front_x", e.fx, front_x_o);
        check_field("front_y", e.fy, front_y_o);
        check_field("front_z", e.fz, front_z_o);
        check_field("bad_input", 32'(e.bad), 32'(bad_input_o));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // ---------------- stimulus ----------------
  task automatic send_cmd(input kind_e k, input logic [31:0] x, input logic [31:0] y,
                          input logic [31:0] z, input logic [31:0] a,
                          input bit typed, input frame_t tex);
    frame_t pex;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    kind <= k; vx <= x; vy <= y; vz <= z; ang <= a;
    do @(posedge clk_i); while (in_stall_o);
    apply_cmd(k, x, y, z, a, pex);
    frame_q.push_back(typed ? tex : pex);
  endtask

  task automatic write_tol(input logic [30:0] t);
    in_valid <= 1'b0;
    wait (frame_q.size() == 0);
    repeat (400) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= t;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    tol = longint'(t);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(2000)) - 32'd1000;
      2: return $urandom_range(1) ? 32'($urandom_range(32'h4000_0000))
                                  : -32'($urandom_range(32'h4000_0000));
      default: begin
        case ($urandom_range(2))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  task automatic rand_cmd();
    kind_e k;
    logic [31:0] v[3], a;
    longint src[3];
    int r, sel;
    frame_t none;
    none = '0;
    r = $urandom_range(99);
    k = r < 5 ? K_NONE : r < 40 ? K_ROTATE : r < 70 ? K_SET_UP : K_SET_FRONT;
    sel = $urandom_range(9);
    if (k == K_SET_UP) begin
      src = front_v;
    end else begin
      src = up_v;
    end
    for (int i = 0; i < 3; i++) begin
      case (sel)
        0: v[i] = $urandom_range(2) == 0 ? rand_comp() : 32'h0;
        1, 2: v[i] = 32'((sel == 1 ? src[i] : -src[i]) + longint'($urandom_range(200)) - 100);
        3: v[i] = 32'h0;
        default: v[i] = rand_comp();
      endcase
    end
    // axis-aligned vector, random sign
    if (sel == 3) v[$urandom_range(2)] = $urandom_range(1) ? P1 : M1;
    case ($urandom_range(5))
      0: a = 32'h0;
      1: a = $urandom;
      2: a = $urandom_range(1) ? 32'(MAX_ANG) : -32'(MAX_ANG);
      default: a = 32'(longint'($urandom_range(32'(2 * MAX_ANG))) - MAX_ANG);
    endcase
    send_cmd(k, v[0], v[1], v[2], a, 1'b0, none);
  endtask

  initial begin
    frame_t none;
    logic [30:0] tols[4];
    none = '0;
    tol = longint'(TOL_RESET);
    up_v = '{0, 0, longint'(1) << FRAC_BITS};
    front_v = '{0, longint'(1) << FRAC_BITS, 0};

    dir_rows = '{
      '{K_NONE, 0, 0, 0, 0, 1, '{0, 0, P1, 0, P1, 0, 0}},
      '{K_ROTATE, 0, 0, 0, 0, 1, '{0, 0, P1, 0, P1, 0, 0}},
      '{K_ROTATE, 0, 0, 0, 100, 1, '{0, 0, P1, 0, P1, 0, 1}},
      '{K_SET_UP, 0, 0, 0, 0, 1, '{0, 0, P1, 0, P1, 0, 1}},
      '{K_SET_FRONT, 0, 0, 0, 0, 1, '{0, 0, P1, 0, P1, 0, 1}},
      '{K_SET_UP, 0, 0, 5, 0, 1, '{0, 0, P1, 0, P1, 0, 0}},
      // front antiparallel to up: up falls back to x
      '{K_SET_FRONT, 0, 0, -7, 0, 1, '{P1, 0, 0, 0, 0, M1, 0}},
      '{K_SET_UP, 0, 1, 0, 0, 1, '{0, P1, 0, 0, 0, M1, 0}},
      '{K_SET_UP, 0, 0, -3, 0, 1, '{0, 0, M1, 0, 0, P1, 0}},
      '{K_SET_UP, 9, 0, 0, 0, 1, '{P1, 0, 0, 0, 0, P1, 0}},
      '{K_ROTATE, 0, 0, 1, 32'(MAX_ANG), 0, none},
      '{K_ROTATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -32'(MAX_ANG), 0, none},
      '{K_ROTATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
      '{K_ROTATE, 1, 0, 0, 32'h8000_0000, 0, none},
      '{K_ROTATE, 0, 0, P1, 1, 0, none},
      '{K_SET_FRONT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, none},
      '{K_SET_UP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, none},
      '{K_SET_FRONT, 1, 1, 1, 0, 0, none},
      '{K_NONE, 32'hDEAD_BEEF, 32'h1234_5678, 32'h8000_0001, 32'hFFFF_FFFF, 0, none}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].kind, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
               dir_rows[i].a, dir_rows[i].typed, dir_rows[i].ex);

    tols = '{31'd0, 31'h4000_0000, 31'($urandom_range(1 << 20)), TOL_RESET};
    for (int b = 0; b < 4; b++) begin
      write_tol(tols[b]);
      send_idle = b == 0 ? 8 : b == 1 ? 53 : 0;
      recv_idle = b == 0 ? 53 : b == 1 ? 8 : 0;
      repeat (470) rand_cmd();
    end
    in_valid <= 1'b0;

    wait (frame_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (!failed && frame_q.size() == 0) begin
      $display("orientation_frame_update_tb: PASS");
    end else begin
      $display("orientation_frame_update_tb: FAIL");
    end
    $finish;
  end

endmodule
